[hdl/rgb_to_spectrum_basis_mix_macros.svh]
// Assertion macros for the RTL of the basis-mix spectrum block.
// Each macro expands to a concurrent assertion on clk, disabled in rst.
// Needs signals named clk and rst in the module that uses it.
`ifndef RGB_TO_SPECTRUM_BASIS_MIX_MACROS_SVH
`define RGB_TO_SPECTRUM_BASIS_MIX_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define RTSBM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rtsbm: same-cycle check failed");
// Next-cycle implication.
`define RTSBM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rtsbm: next-cycle check failed");
`else
`define RTSBM_ASSERT_IMP(name, ante, cons)
`define RTSBM_ASSERT_NXT(name, ante, cons)
`endif
`endif

[hdl/rtsbm_pkg.sv]
// Shared types and constants for the RGB-to-spectrum basis-mix block.
// Used by the front end, queue, back end and top level. No dependencies.
`default_nettype none

package rtsbm_pkg;

  // Default number of wavelength samples per spectrum
  localparam int SAMPLES_DEF = 10;
  localparam int NUM_BASES   = 7;

  // Field widths
  localparam int VAL_W    = 20;
  localparam int CHAN_W   = 18;
  localparam int WEIGHT_W = 17;
  localparam int IDX_W    = 4;

  // Request kinds (tuser on the input side)
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_CONVERT = 1'b1;

  // Basis codes
  localparam logic [2:0] BASIS_WHITE   = 3'd0;
  localparam logic [2:0] BASIS_CYAN    = 3'd1;
  localparam logic [2:0] BASIS_MAGENTA = 3'd2;
  localparam logic [2:0] BASIS_YELLOW  = 3'd3;
  localparam logic [2:0] PRIM_RED      = 3'd4;
  localparam logic [2:0] PRIM_GREEN    = 3'd5;
  localparam logic [2:0] PRIM_BLUE     = 3'd6;

  // Q16 one
  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'd65536;

  // Job queue geometry
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef logic [WEIGHT_W-1:0] weight_t;

  // One classified convert item: weights and the two mixing bases
  typedef struct packed {
    weight_t    wmin;
    weight_t    w2;
    weight_t    w1;
    logic [2:0] second;
    logic [2:0] prim;
  } job_t;

  // Queue status toward the front end
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

`default_nettype wire

[hdl/rtsbm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package needed.
`default_nettype none

module rtsbm_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 70,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AddrW-1:0] raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/rtsbm_front.sv]
// Front end: accepts items, writes table loads, classifies convert items.
// Depends on rtsbm_pkg; feeds rtsbm_queue and the table RAMs.
`default_nettype none

module rtsbm_front #(
  parameter int SAMPLES = rtsbm_pkg::SAMPLES_DEF,
  localparam int AddrW = $clog2(rtsbm_pkg::NUM_BASES * SAMPLES)
) (
  // input item stream
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [87:0]                  s_axis_tdata,
  input  wire logic                         s_axis_tuser,
  // queue side
  input  wire rtsbm_pkg::queue_status_t     q_stat,
  input  wire logic                         back_idle,
  output logic                              q_push,
  output rtsbm_pkg::job_t                   q_job,
  // table write port
  output logic                              tbl_we,
  output logic [AddrW-1:0]                  tbl_waddr,
  output logic [rtsbm_pkg::VAL_W-1:0]       tbl_wdata
);

  logic                                     is_conv;
  logic                                     fire;
  logic [2:0]                               sel;
  logic [rtsbm_pkg::IDX_W-1:0]              idx;
  logic signed [rtsbm_pkg::CHAN_W-1:0]      red_in;
  logic signed [rtsbm_pkg::CHAN_W-1:0]      green_in;
  logic signed [rtsbm_pkg::CHAN_W-1:0]      blue_in;
  rtsbm_pkg::weight_t                       rc;
  rtsbm_pkg::weight_t                       gc;
  rtsbm_pkg::weight_t                       bc;

  // Clamp a signed Q16 channel to 0..1
  function automatic rtsbm_pkg::weight_t clamp_unit(
    input logic signed [rtsbm_pkg::CHAN_W-1:0] x
  );
    rtsbm_pkg::weight_t res;
    if (x[rtsbm_pkg::CHAN_W-1]) begin
      res = '0;
    end else if (x[rtsbm_pkg::CHAN_W-2:0] > rtsbm_pkg::ONE_Q16) begin
      res = rtsbm_pkg::ONE_Q16;
    end else begin
      res = x[rtsbm_pkg::WEIGHT_W-1:0];
    end
    return res;
  endfunction

  // Unpack fields
  assign sel      = s_axis_tdata[2:0];
  assign idx      = s_axis_tdata[6:3];
  assign tbl_wdata = s_axis_tdata[26:7];
  assign red_in   = s_axis_tdata[44:27];
  assign green_in = s_axis_tdata[62:45];
  assign blue_in  = s_axis_tdata[80:63];

  // Loads wait until no conversion is queued or in flight
  assign is_conv       = (s_axis_tuser == rtsbm_pkg::REQ_CONVERT);
  assign s_axis_tready = is_conv ? !q_stat.full : (q_stat.empty && back_idle);
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign q_push        = fire && is_conv;

  // Table write; out-of-range basis or sample index is dropped
  assign tbl_we = fire && !is_conv && (sel <= rtsbm_pkg::PRIM_BLUE)
                  && (32'(idx) < SAMPLES);
  assign tbl_waddr = AddrW'(32'(sel) * SAMPLES + 32'(idx));

  assign rc = clamp_unit(red_in);
  assign gc = clamp_unit(green_in);
  assign bc = clamp_unit(blue_in);

  // Pick minimum channel (red, then green, then blue on ties) and weights
  always_comb begin
    q_job = '0;
    priority if (rc <= gc && rc <= bc) begin
      q_job.wmin   = rc;
      q_job.second = rtsbm_pkg::BASIS_CYAN;
      if (gc <= bc) begin
        q_job.w2 = gc - rc; q_job.prim = rtsbm_pkg::PRIM_BLUE;  q_job.w1 = bc - gc;
      end else begin
        q_job.w2 = bc - rc; q_job.prim = rtsbm_pkg::PRIM_GREEN; q_job.w1 = gc - bc;
      end
    end else if (gc <= rc && gc <= bc) begin
      q_job.wmin   = gc;
      q_job.second = rtsbm_pkg::BASIS_MAGENTA;
      if (rc <= bc) begin
        q_job.w2 = rc - gc; q_job.prim = rtsbm_pkg::PRIM_BLUE;  q_job.w1 = bc - rc;
      end else begin
        q_job.w2 = bc - gc; q_job.prim = rtsbm_pkg::PRIM_RED;   q_job.w1 = rc - bc;
      end
    end else begin
      q_job.wmin   = bc;
      q_job.second = rtsbm_pkg::BASIS_YELLOW;
      if (rc <= gc) begin
        q_job.w2 = rc - bc; q_job.prim = rtsbm_pkg::PRIM_GREEN; q_job.w1 = gc - rc;
      end else begin
        q_job.w2 = gc - bc; q_job.prim = rtsbm_pkg::PRIM_RED;   q_job.w1 = rc - gc;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/rtsbm_queue.sv]
// Short job queue between the front end and the back end.
// Depends on rtsbm_pkg for the job type and depth.
`default_nettype none

module rtsbm_queue (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      push,
  input  wire rtsbm_pkg::job_t           push_job,
  input  wire logic                      pop,
  output logic                           q_valid,
  output rtsbm_pkg::job_t                q_job,
  output rtsbm_pkg::queue_status_t       q_stat
);

  rtsbm_pkg::job_t                       entries [rtsbm_pkg::QDEPTH];
  logic [rtsbm_pkg::QPTR_W-1:0]          wr_ptr;
  logic [rtsbm_pkg::QPTR_W-1:0]          rd_ptr;
  logic [rtsbm_pkg::QCNT_W-1:0]          count;

  assign q_valid      = (count != '0);
  assign q_job        = entries[rd_ptr];
  assign q_stat.empty = (count == '0);
  assign q_stat.full  = (count == rtsbm_pkg::QCNT_W'(rtsbm_pkg::QDEPTH));

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/rtsbm_back.sv]
// Back end: walks the samples of one job, reads three table entries per
// sample, multiplies, sums, rounds and saturates. Depends on rtsbm_pkg.
`default_nettype none
`include "rgb_to_spectrum_basis_mix_macros.svh"

module rtsbm_back #(
  parameter int SAMPLES = rtsbm_pkg::SAMPLES_DEF,
  localparam int AddrW = $clog2(rtsbm_pkg::NUM_BASES * SAMPLES)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          clamp_neg,
  // job queue
  input  wire logic                          q_valid,
  input  wire rtsbm_pkg::job_t               q_job,
  output logic                               q_pop,
  output logic                               back_idle,
  // table read ports
  output logic                               tbl_re,
  output logic [AddrW-1:0]                   raddr_w,
  output logic [AddrW-1:0]                   raddr_s,
  output logic [AddrW-1:0]                   raddr_p,
  input  wire logic [rtsbm_pkg::VAL_W-1:0]   rdata_w,
  input  wire logic [rtsbm_pkg::VAL_W-1:0]   rdata_s,
  input  wire logic [rtsbm_pkg::VAL_W-1:0]   rdata_p,
  // result stream
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [23:0]                        m_axis_tdata,
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int CntW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int IdxW = rtsbm_pkg::IDX_W;
  localparam logic [CntW-1:0] LastCnt = CntW'(SAMPLES - 1);
  localparam logic [31:0] LastIdx32 = 32'(SAMPLES - 1);
  localparam logic [rtsbm_pkg::IDX_W-1:0] LastIdx = LastIdx32[rtsbm_pkg::IDX_W-1:0];
  localparam logic signed [23:0] ValMax = 24'sd524287;
  localparam logic signed [23:0] ValMin = -24'sd524288;
  localparam logic [rtsbm_pkg::VAL_W-1:0] SatHi = ValMax[rtsbm_pkg::VAL_W-1:0];
  localparam logic [rtsbm_pkg::VAL_W-1:0] SatLo = ValMin[rtsbm_pkg::VAL_W-1:0];

  // sequencer
  logic                                  busy;
  logic [CntW-1:0]                       cnt;
  rtsbm_pkg::weight_t                    cur_wmin;
  rtsbm_pkg::weight_t                    cur_w2;
  rtsbm_pkg::weight_t                    cur_w1;
  logic                                  adv;
  logic                                  issue;
  logic                                  issue_last;

  // stage 1: table data valid
  logic                                  s1_valid;
  rtsbm_pkg::weight_t                    s1_wmin;
  rtsbm_pkg::weight_t                    s1_w2;
  rtsbm_pkg::weight_t                    s1_w1;
  logic [rtsbm_pkg::IDX_W-1:0]           s1_idx;
  logic                                  s1_last;

  // stage 2: products
  logic                                  s2_valid;
  logic signed [37:0]                    p_w;
  logic signed [37:0]                    p_s;
  logic signed [37:0]                    p_p;
  logic [rtsbm_pkg::IDX_W-1:0]           s2_idx;
  logic                                  s2_last;

  // final sum and rounding
  logic signed [39:0]                    acc;
  logic signed [39:0]                    rnd;
  logic signed [23:0]                    v_round;
  logic signed [23:0]                    v_clip;
  logic signed [23:0]                    v_sat;
  logic                                  sat_next;

  // output register
  logic [rtsbm_pkg::IDX_W-1:0]           out_idx;
  logic [rtsbm_pkg::VAL_W-1:0]           out_val;

  // Whole pipeline moves when the output register can take a value
  assign adv        = !m_axis_tvalid || m_axis_tready;
  assign issue      = busy && adv;
  assign issue_last = issue && (cnt == LastCnt);
  assign q_pop      = q_valid && (!busy || issue_last);
  assign back_idle  = !busy;

  assign tbl_re = adv;

  // Sample sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_pop) begin
      busy <= 1'b1;
    end else if (issue_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cnt      <= '0;
      raddr_w  <= '0;
      raddr_s  <= AddrW'(32'(q_job.second) * SAMPLES);
      raddr_p  <= AddrW'(32'(q_job.prim) * SAMPLES);
      cur_wmin <= q_job.wmin;
      cur_w2   <= q_job.w2;
      cur_w1   <= q_job.w1;
    end else if (issue) begin
      cnt     <= cnt + 1'b1;
      raddr_w <= raddr_w + 1'b1;
      raddr_s <= raddr_s + 1'b1;
      raddr_p <= raddr_p + 1'b1;
    end
  end

  // Stage 1 control: matches the registered RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_wmin <= cur_wmin;
      s1_w2   <= cur_w2;
      s1_w1   <= cur_w1;
      s1_idx  <= IdxW'(cnt);
      s1_last <= (cnt == LastCnt);
    end
  end

  // Stage 2: one multiplier per basis
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_w    <= 38'($signed(rdata_w)) * 38'($signed({1'b0, s1_wmin}));
      p_s    <= 38'($signed(rdata_s)) * 38'($signed({1'b0, s1_w2}));
      p_p    <= 38'($signed(rdata_p)) * 38'($signed({1'b0, s1_w1}));
      s2_idx <= s1_idx;
      s2_last <= s1_last;
    end
  end

  // Sum, round half up, optional zeroing of negatives, saturate
  always_comb begin
    acc     = {{2{p_w[37]}}, p_w} + {{2{p_s[37]}}, p_s} + {{2{p_p[37]}}, p_p};
    rnd     = acc + 40'sd32768;
    v_round = rnd[39:16];
    v_clip  = (clamp_neg && v_round < 0) ? 24'sd0 : v_round;
    sat_next = 1'b0;
    v_sat    = v_clip;
    if (v_clip > ValMax) begin
      v_sat    = ValMax;
      sat_next = 1'b1;
    end else if (v_clip < ValMin) begin
      v_sat    = ValMin;
      sat_next = 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_idx      <= s2_idx;
      out_val      <= v_sat[rtsbm_pkg::VAL_W-1:0];
      m_axis_tuser <= sat_next;
      m_axis_tlast <= s2_last;
    end
  end

  assign m_axis_tdata = {out_val, out_idx};

  // Checks
  `RTSBM_ASSERT_IMP(a_last_index, m_axis_tvalid && m_axis_tlast, out_idx == LastIdx)
  `RTSBM_ASSERT_IMP(a_sat_extreme, m_axis_tvalid && m_axis_tuser, out_val == SatHi || out_val == SatLo)
  `RTSBM_ASSERT_NXT(a_job_end, issue_last && !q_valid, !busy)
  `RTSBM_ASSERT_NXT(a_job_start, q_pop, busy && cnt == '0)

endmodule

`default_nettype wire

[hdl/rgb_to_spectrum_basis_mix.sv]
// Top level of the RGB-to-spectrum basis-mix block (reflectance spectra).
// Depends on rtsbm_pkg, rtsbm_front, rtsbm_queue, rtsbm_back, rtsbm_ram.
//
//   port group   dir   payload (low bit first)
//   s_axis_*     in    tuser: req_type; tdata: basis_select, load_index,
//                      basis_value, red_in, green_in, blue_in
//   m_axis_*     out   tdata: sample_index, sample_value; tuser: saturated;
//                      tlast: last
//   cfg_*        in    clamp_negative
//
// A convert item yields SAMPLES results, one per cycle while the output
// is not stalled, from the sequencer that walks the three basis table RAMs.
// The next queued convert starts as the last sample of the current one issues;
// two queue slots. A load item waits until all queued converts have been
// read out of the table. Reset clears control only; table contents are
// undefined until loaded. A stalled output stalls the whole back end.
`default_nettype none

module rgb_to_spectrum_basis_mix #(
  parameter int SAMPLES = rtsbm_pkg::SAMPLES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,     // clamp_negative
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [87:0] s_axis_tdata,  // basis_select[2:0], load_index[6:3],
                                          // basis_value[26:7], red_in[44:27],
                                          // green_in[62:45], blue_in[80:63]
  input  wire logic        s_axis_tuser,  // req_type
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,  // sample_index[3:0], sample_value[23:4]
  output logic             m_axis_tuser,  // saturated
  output logic             m_axis_tlast
);

  localparam int TableDepth = rtsbm_pkg::NUM_BASES * SAMPLES;
  localparam int AddrW      = $clog2(TableDepth);

  logic                              clamp_neg;
  rtsbm_pkg::queue_status_t          q_stat;
  logic                              back_idle;
  logic                              q_push;
  rtsbm_pkg::job_t                   push_job;
  logic                              q_valid;
  rtsbm_pkg::job_t                   q_job;
  logic                              q_pop;
  logic                              tbl_we;
  logic [AddrW-1:0]                  tbl_waddr;
  logic [rtsbm_pkg::VAL_W-1:0]       tbl_wdata;
  logic                              tbl_re;
  logic [AddrW-1:0]                  raddr_w;
  logic [AddrW-1:0]                  raddr_s;
  logic [AddrW-1:0]                  raddr_p;
  logic [rtsbm_pkg::VAL_W-1:0]       rdata_w;
  logic [rtsbm_pkg::VAL_W-1:0]       rdata_s;
  logic [rtsbm_pkg::VAL_W-1:0]       rdata_p;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_neg <= 1'b0;
    end else if (cfg_we) begin
      clamp_neg <= cfg_wdata;
    end
  end

  rtsbm_front #(.SAMPLES(SAMPLES)) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_stat        (q_stat),
    .back_idle     (back_idle),
    .q_push        (q_push),
    .q_job         (push_job),
    .tbl_we        (tbl_we),
    .tbl_waddr     (tbl_waddr),
    .tbl_wdata     (tbl_wdata)
  );

  rtsbm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .q_stat   (q_stat)
  );

  // One table copy per read port: white, secondary, primary
  rtsbm_ram #(.WIDTH(rtsbm_pkg::VAL_W), .DEPTH(TableDepth)) u_ram_w (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (raddr_w),
    .rdata (rdata_w)
  );

  rtsbm_ram #(.WIDTH(rtsbm_pkg::VAL_W), .DEPTH(TableDepth)) u_ram_s (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (raddr_s),
    .rdata (rdata_s)
  );

  rtsbm_ram #(.WIDTH(rtsbm_pkg::VAL_W), .DEPTH(TableDepth)) u_ram_p (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .re    (tbl_re),
    .raddr (raddr_p),
    .rdata (rdata_p)
  );

  rtsbm_back #(.SAMPLES(SAMPLES)) u_back (
    .clk           (clk),
    .rst           (rst),
    .clamp_neg     (clamp_neg),
    .q_valid       (q_valid),
    .q_job         (q_job),
    .q_pop         (q_pop),
    .back_idle     (back_idle),
    .tbl_re        (tbl_re),
    .raddr_w       (raddr_w),
    .raddr_s       (raddr_s),
    .raddr_p       (raddr_p),
    .rdata_w       (rdata_w),
    .rdata_s       (rdata_s),
    .rdata_p       (rdata_p),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire
